// ===== rtl/core/qrrs_pkg.sv =====
package qrrs_pkg;

    localparam int MAX_PARITY = 30;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = $clog2(MAX_PARITY + 1);

    localparam logic [BYTE_W:0]  PRIM_POLY   = 9'h11D;
    localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(10);

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  count_t;

    // GF(256) multiply, shift-and-add with reduction by the field polynomial.
    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        logic [BYTE_W:0] x;
        byte_t           acc;
        begin
            acc = '0;
            x   = {1'b0, a};
            for (int k = 0; k < BYTE_W; k++) begin
                if (b[k]) begin
                    acc = acc ^ x[BYTE_W-1:0];
                end
                x = {x[BYTE_W-1:0], 1'b0};
                if (x[BYTE_W]) begin
                    x = x ^ PRIM_POLY;
                end
            end
            return acc;
        end
    endfunction

    // Multiply by alpha.
    function automatic byte_t gf_xtime(input byte_t a);
        logic [BYTE_W:0] x;
        begin
            x = {a, 1'b0};
            if (x[BYTE_W]) begin
                x = x ^ PRIM_POLY;
            end
            return x[BYTE_W-1:0];
        end
    endfunction

    // Parity count clamped to the supported range.
    function automatic count_t eff_count(input count_t v);
        begin
            if (v == '0) begin
                return CNT_W'(1);
            end
            if (v > CNT_W'(MAX_PARITY)) begin
                return CNT_W'(MAX_PARITY);
            end
            return v;
        end
    endfunction

endpackage

// ===== rtl/core/qr_reed_solomon_parity_unit.sv =====
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D.
// Input channel (s_valid/s_ready): one data byte per beat; s_block_end marks the
// last data byte of a block. Result channel (m_valid/m_ready): the parity bytes
// of that block, highest-order first, with m_parity_last on the final one.
// cfg_we/cfg_wdata set the parity count; 0 acts as 1 and values above the
// maximum act as the maximum. Writes are to be made only while the block is
// idle; the block does not enforce this. After reset (count 10) and each write,
// the generator polynomial is built one root per cycle, with s_ready low
// until all n roots (n = effective count) are in; any partial block is dropped.
// Throughput: one data beat per cycle except during builds and block-end stalls.
// The division register update runs all multipliers in parallel between the
// input register and the remainder register. A block-end beat loads the parity
// buffer as it leaves the input register; its n parity beats then leave at one
// per cycle while m_ready is high. The parity bytes sit in their own output
// shift register, so data beats of the next block keep flowing while they drain.
// Only a second block-end beat waits in the input register until that buffer
// is empty (or emptying); a stalled receiver backs up input only at block ends.
module qr_reed_solomon_parity_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [qrrs_pkg::CNT_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [qrrs_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic                            s_block_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [qrrs_pkg::BYTE_W-1:0]     m_parity_byte,
    output logic                            m_parity_last
);

    localparam int MP = qrrs_pkg::MAX_PARITY;

    // Generator coefficients; entry 0 is the leading 1.
    qrrs_pkg::byte_t  gen_reg [MP+1];
    qrrs_pkg::byte_t  gen_next [MP+1];
    qrrs_pkg::byte_t  root_reg;
    qrrs_pkg::count_t build_cnt_reg;
    qrrs_pkg::count_t n_reg;

    // Division register and the input stage feeding it.
    qrrs_pkg::byte_t  rem_reg [MP];
    qrrs_pkg::byte_t  rem_next [MP];
    qrrs_pkg::byte_t  in_byte_reg;
    logic             in_end_reg;
    logic             in_valid_reg;
    qrrs_pkg::byte_t  factor;

    // Output shift register of parity bytes.
    qrrs_pkg::byte_t  par_reg [MP];
    qrrs_pkg::count_t par_cnt_reg;

    logic building;
    logic par_free;
    logic advance;
    logic pop;
    logic load;

    assign building = (build_cnt_reg != '0);
    assign m_valid  = (par_cnt_reg != '0);
    assign m_parity_byte = par_reg[0];
    assign m_parity_last = (par_cnt_reg == qrrs_pkg::CNT_W'(1));
    assign pop      = m_valid && m_ready;

    // A block end may enter the buffer once it is empty or its last beat leaves now.
    assign par_free = (par_cnt_reg == '0) || (m_parity_last && m_ready);
    assign advance  = in_valid_reg && (!in_end_reg || par_free);
    assign load     = advance && in_end_reg;
    assign s_ready  = !building && (!in_valid_reg || advance);

    assign factor = in_byte_reg ^ rem_reg[0];

    // The remainder and generator hold zeros above the current degree,
    // so every lane can be updated the same way.
    always_comb begin
        for (int i = 0; i < MP - 1; i++) begin
            rem_next[i] = rem_reg[i+1] ^ qrrs_pkg::gf_mul(gen_reg[i+1], factor);
        end
        rem_next[MP-1] = qrrs_pkg::gf_mul(gen_reg[MP], factor);
        gen_next[0] = gen_reg[0];
        for (int j = 1; j <= MP; j++) begin
            gen_next[j] = gen_reg[j] ^ qrrs_pkg::gf_mul(gen_reg[j-1], root_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            // Start a generator build: g(x) = 1, first root alpha^0.
            for (int j = 0; j <= MP; j++) begin
                gen_reg[j] <= (j == 0) ? qrrs_pkg::BYTE_W'(1) : '0;
            end
            for (int i = 0; i < MP; i++) begin
                rem_reg[i] <= '0;
            end
            root_reg      <= qrrs_pkg::BYTE_W'(1);
            build_cnt_reg <= qrrs_pkg::eff_count(aresetn ? cfg_wdata
                                                         : qrrs_pkg::RESET_COUNT);
            n_reg         <= qrrs_pkg::eff_count(aresetn ? cfg_wdata
                                                         : qrrs_pkg::RESET_COUNT);
            in_valid_reg  <= 1'b0;
            par_cnt_reg   <= '0;
        end else begin
            if (building) begin
                gen_reg       <= gen_next;
                root_reg      <= qrrs_pkg::gf_xtime(root_reg);
                build_cnt_reg <= build_cnt_reg - qrrs_pkg::CNT_W'(1);
            end

            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_data_byte;
                in_end_reg   <= s_block_end;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                for (int i = 0; i < MP; i++) begin
                    rem_reg[i] <= in_end_reg ? '0 : rem_next[i];
                end
            end

            if (load) begin
                par_reg     <= rem_next;
                par_cnt_reg <= n_reg;
            end else if (pop) begin
                for (int i = 0; i < MP - 1; i++) begin
                    par_reg[i] <= par_reg[i+1];
                end
                par_reg[MP-1] <= '0;
                par_cnt_reg <= par_cnt_reg - qrrs_pkg::CNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_while_building: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && building))
        else $error("input accepted during generator build");

    a_block_loads_n: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !cfg_we) |=> (par_cnt_reg == $past(n_reg)))
        else $error("parity buffer not loaded with the parity count");

    a_rem_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !cfg_we) |=> (rem_reg[0] == '0))
        else $error("remainder not cleared at block end");

    a_build_counts_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (building && !cfg_we) |=>
            (build_cnt_reg == $past(build_cnt_reg) - qrrs_pkg::CNT_W'(1)))
        else $error("generator build counter stalled");

    a_gen_leading_one: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_reg[0] == qrrs_pkg::BYTE_W'(1))
        else $error("generator leading coefficient corrupted");
`endif

endmodule

// ===== bench/tb_qr_reed_solomon_parity_unit.sv =====
module tb_qr_reed_solomon_parity_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Low byte of the field polynomial 0x11D, folded back in when a shift carries out.
    localparam qrrs_pkg::byte_t FIELD_FOLD = 8'h1D;
    localparam qrrs_pkg::byte_t ALPHA = 8'h02;

    // A long receiver hold-off lets the output buffer fill and back up the input.
    localparam int HOLD_CYCLES = 400;
    // Cycles allowed for trailing data beats to settle before a count write.
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        qrrs_pkg::byte_t data;
        logic            last;
    } data_beat_t;

    typedef struct packed {
        qrrs_pkg::byte_t parity;
        logic            last;
    } parity_beat_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    qrrs_pkg::count_t cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    qrrs_pkg::byte_t  s_data_byte = '0;
    logic             s_block_end = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    qrrs_pkg::byte_t  m_parity_byte;
    logic             m_parity_last;

    qr_reed_solomon_parity_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_block_end   (s_block_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_parity_byte (m_parity_byte),
        .m_parity_last (m_parity_last)
    );

    always #6 aclk = ~aclk;

    // Data beats waiting to be offered, and the parity beats the encoder owes us.
    data_beat_t   pending_data_q[$];
    parity_beat_t owed_parity_q[$];

    // Shadow copy of the encoder: the clamped degree, the generator polynomial
    // (leading coefficient first) and the division register.
    int              degree;
    qrrs_pkg::byte_t gen_poly [qrrs_pkg::MAX_PARITY+1];
    qrrs_pkg::byte_t remainder [qrrs_pkg::MAX_PARITY];

    // Traffic shaping. The pressure process owns rx_hold; the sequence only
    // sets hold_go to start it.
    bit   calm = 1'b0;
    bit   hold_go = 1'b0;
    logic rx_hold = 1'b0;
    int   tx_gap = 0;
    int   rx_gap = 0;

    int error_count = 0;
    int data_beats = 0;
    int blocks_closed = 0;
    int parity_beats = 0;
    int count_writes = 0;

    // GF(256) product by repeated doubling of a and adding where b has a one.
    function automatic qrrs_pkg::byte_t gf_times(input qrrs_pkg::byte_t a,
                                                 input qrrs_pkg::byte_t b);
        qrrs_pkg::byte_t prod;
        qrrs_pkg::byte_t sh;
        qrrs_pkg::byte_t mul;
        prod = '0;
        sh   = a;
        mul  = b;
        while (mul != '0) begin
            if (mul[0]) begin
                prod = prod ^ sh;
            end
            sh  = {sh[6:0], 1'b0} ^ (sh[7] ? FIELD_FOLD : 8'h00);
            mul = mul >> 1;
        end
        return prod;
    endfunction

    // Programming the count rebuilds g(x) = prod (x + alpha^i), i = 0..degree-1,
    // and throws away whatever partial block sat in the division register.
    function automatic void load_parity_count(input qrrs_pkg::count_t value);
        qrrs_pkg::byte_t root;
        if (value == '0) begin
            degree = 1;
        end else if (int'(value) > qrrs_pkg::MAX_PARITY) begin
            degree = qrrs_pkg::MAX_PARITY;
        end else begin
            degree = int'(value);
        end
        foreach (gen_poly[k]) begin
            gen_poly[k] = '0;
        end
        gen_poly[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < degree; i++) begin
            for (int j = i + 1; j >= 1; j--) begin
                gen_poly[j] = gen_poly[j] ^ gf_times(gen_poly[j-1], root);
            end
            root = gf_times(root, ALPHA);
        end
        foreach (remainder[k]) begin
            remainder[k] = '0;
        end
    endfunction

    // One LFSR division step. A block-end beat then owes the whole remainder,
    // highest-order byte first, and the register starts over from zero.
    function automatic void absorb_data_beat(input qrrs_pkg::byte_t data, input logic last);
        qrrs_pkg::byte_t factor;
        parity_beat_t    owed;
        factor = data ^ remainder[0];
        for (int i = 0; i < degree - 1; i++) begin
            remainder[i] = remainder[i+1];
        end
        remainder[degree-1] = '0;
        for (int i = 0; i < degree; i++) begin
            remainder[i] = remainder[i] ^ gf_times(gen_poly[i+1], factor);
        end
        if (last) begin
            for (int i = 0; i < degree; i++) begin
                owed.parity = remainder[i];
                owed.last   = (i == degree - 1);
                owed_parity_q = {owed_parity_q, owed};
            end
            foreach (remainder[k]) begin
                remainder[k] = '0;
            end
        end
    endfunction

    // Sender. The beat on the wire is always the head of pending_data_q; it is
    // popped and fed to the shadow encoder at the edge where it is accepted.
    // Gaps are chosen only between beats, so valid never drops under a stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_data_beat(s_data_byte, s_block_end);
                void'(pending_data_q.pop_front());
                data_beats++;
                if (s_block_end) begin
                    blocks_closed++;
                end
            end
            if (s_valid && !s_ready) begin
                // Still waiting for the current beat to be taken.
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (!calm && pending_data_q.size() > 0 && $urandom_range(0, 7) == 0) begin
                tx_gap = $urandom_range(1, 15) - 1;
                s_valid <= 1'b0;
            end else if (pending_data_q.size() > 0) begin
                s_valid     <= 1'b1;
                s_data_byte <= pending_data_q[0].data;
                s_block_end <= pending_data_q[0].last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver. Every parity beat taken is checked against the oldest one owed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                parity_beats++;
                if (owed_parity_q.size() == 0) begin
                    $error("unexpected parity beat: m_parity_byte %02h m_parity_last %0b",
                           m_parity_byte, m_parity_last);
                    error_count++;
                end else begin
                    if (m_parity_byte !== owed_parity_q[0].parity) begin
                        $error("m_parity_byte expected %02h actual %02h",
                               owed_parity_q[0].parity, m_parity_byte);
                        error_count++;
                    end
                    if (m_parity_last !== owed_parity_q[0].last) begin
                        $error("m_parity_last expected %0b actual %0b",
                               owed_parity_q[0].last, m_parity_last);
                        error_count++;
                    end
                    void'(owed_parity_q.pop_front());
                end
            end
            if (rx_hold) begin
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(1, 15) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Pressure: once started, the receiver refuses parity beats while rx_hold is
    // set, and the sender keeps offering whole blocks.
    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4ms;
        $display("** qr_reed_solomon_parity_unit: FAILED **");
        $finish;
    end

    task automatic queue_beat(input qrrs_pkg::byte_t data, input logic last);
        data_beat_t beat;
        beat.data = data;
        beat.last = last;
        pending_data_q = {pending_data_q, beat};
    endtask

    // A block of random bytes; an open block has no block-end beat and is later
    // dropped by the next count write.
    task automatic queue_block(input int len, input bit closed);
        for (int k = 0; k < len; k++) begin
            queue_beat(qrrs_pkg::byte_t'($urandom_range(0, 255)),
                       closed && (k == len - 1));
        end
    endtask

    // The count is only written with nothing in flight, so the shadow model can
    // take the new value at once.
    task automatic write_parity_count(input qrrs_pkg::count_t value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        load_parity_count(value);
        count_writes++;
        @(negedge aclk);
    endtask

    // Wait until every data beat is taken and every owed parity beat has come
    // back, then give trailing data beats time to land in the remainder.
    task automatic wait_for_quiet();
        do begin
            @(negedge aclk);
        end while (pending_data_q.size() != 0 || s_valid || owed_parity_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Mostly short blocks, now and then a long one; sometimes the phase ends
    // in the middle of a block.
    task automatic random_phase(input qrrs_pkg::count_t value, input int beats);
        int sent;
        int len;
        sent = 0;
        write_parity_count(value);
        while (sent < beats) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            queue_block(len, 1'b1);
            sent += len;
        end
        if ($urandom_range(0, 2) == 0) begin
            queue_block($urandom_range(1, 3), 1'b0);
        end
        wait_for_quiet();
    endtask

    initial begin
        // The encoder comes out of reset with a count of ten and then builds its
        // generator; the sender simply waits on s_ready.
        load_parity_count(qrrs_pkg::RESET_COUNT);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A block that is only a zero block-end beat leaves all-zero parity.
        queue_beat(8'h00, 1'b1);
        // Data extremes and alternating bit patterns in one block.
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'h80, 1'b0);
        queue_beat(8'h01, 1'b0);
        queue_beat(8'h55, 1'b0);
        queue_beat(8'hAA, 1'b1);
        // A block left open; the count write below must discard it.
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'hFF, 1'b0);
        wait_for_quiet();

        // A count of zero behaves as one parity byte.
        write_parity_count(qrrs_pkg::count_t'(0));
        queue_beat(8'h12, 1'b0);
        queue_beat(8'hFE, 1'b0);
        queue_beat(8'h7F, 1'b0);
        queue_beat(8'h01, 1'b1);
        queue_beat(8'hFF, 1'b1);
        wait_for_quiet();

        // The all-ones count is clamped to the maximum degree.
        write_parity_count(qrrs_pkg::count_t'(31));
        queue_block(6, 1'b1);
        wait_for_quiet();

        random_phase(qrrs_pkg::count_t'(qrrs_pkg::MAX_PARITY), 8);
        random_phase(qrrs_pkg::count_t'(1), 8);
        random_phase(qrrs_pkg::count_t'($urandom_range(2, qrrs_pkg::MAX_PARITY - 1)), 8);
        random_phase(qrrs_pkg::count_t'($urandom_range(0, 31)), 8);

        // Back-to-back blocks against a stalled receiver: the parity buffer
        // fills, the next block-end beat waits, and the input channel stalls.
        write_parity_count(qrrs_pkg::count_t'(qrrs_pkg::MAX_PARITY));
        calm = 1'b1;
        hold_go = 1'b1;
        for (int b = 0; b < 4; b++) begin
            queue_block($urandom_range(3, 6), 1'b1);
        end
        wait_for_quiet();

        // The tail of the run streams at full rate on both sides.
        random_phase(qrrs_pkg::count_t'($urandom_range(1, 31)), 8);

        $display("Sent %0d data beats in %0d blocks over %0d count settings.",
                 data_beats, blocks_closed, count_writes + 1);
        $display("Checked %0d parity beats, including clamped counts and a long stall.",
                 parity_beats);
        if (error_count == 0) begin
            $display("** qr_reed_solomon_parity_unit: PASSED **");
        end else begin
            $display("** qr_reed_solomon_parity_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/qrrs_pkg.sv
rtl/core/qr_reed_solomon_parity_unit.sv
bench/tb_qr_reed_solomon_parity_unit.sv
